FILE: hw/rtl/slp_pkg.sv
// Shared types, character codes and helpers of the serial command line parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package slp_pkg;

  // Default sizes of the line store and the language list
  localparam int LINE_LEN_DEF   = 15;
  localparam int LANG_COUNT_DEF = 6;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int LEVEL_W = 10;
  localparam int TVAL_W  = 13;
  localparam int LANG_W  = 3;
  localparam int ALARM_W = 19;

  // Configuration register indexes
  localparam logic CFG_LEVEL_MIN = 1'b0;
  localparam logic CFG_LEVEL_MAX = 1'b1;

  // Reset values
  localparam logic [CHAR_W-1:0]  FILL_CHAR      = 8'd48;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN_RST  = 10'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX_RST  = 10'd1000;
  localparam logic [LEVEL_W-1:0] STORED_LOW_RST  = 10'd0;
  localparam logic [LEVEL_W-1:0] STORED_HIGH_RST = 10'd1000;

  // Wrap guard tops
  localparam logic [5:0] HOUR_TOP   = 6'd11;
  localparam logic [5:0] MINSEC_TOP = 6'd59;

  // ASCII codes used by the decoder
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CH_H      = 8'h48;
  localparam logic [CHAR_W-1:0] CH_L      = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_M      = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_S      = 8'h53;

  // Two-letter language codes, index 0 first: PT EN EP FR DE IT
  localparam int LANG_CODE_N = 6;
  localparam logic [LANG_CODE_N-1:0][15:0] LANG_CODES = {
    16'h4954, 16'h4445, 16'h4652, 16'h4550, 16'h454E, 16'h5054
  };

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_EXEC   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // Command codes on the output channel
  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_LANGUAGE   = 3'd1,
    CMD_ALARM_LOW  = 3'd2,
    CMD_ALARM_HIGH = 3'd3,
    CMD_TIME       = 3'd4
  } command_t;

  // One input item as held in the input register
  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_in;
    logic [4:0]        now_hours;
    logic [5:0]        now_minutes;
    logic [5:0]        now_seconds;
  } item_t;

  // One result item
  typedef struct packed {
    command_t                  command;
    logic [LANG_W-1:0]         language_sel;
    logic [LEVEL_W-1:0]        level_low;
    logic [LEVEL_W-1:0]        level_high;
    logic                      hours_write;
    logic signed [TVAL_W-1:0]  hours_value;
    logic                      minutes_write;
    logic signed [TVAL_W-1:0]  minutes_value;
    logic                      seconds_write;
    logic signed [TVAL_W-1:0]  seconds_value;
  } result_t;

  // Update request from the pipeline to the line buffer
  typedef struct packed {
    logic              append;
    logic              clear;
    logic [CHAR_W-1:0] char_in;
  } line_op_t;

  // Digit value of a byte, unchecked: byte - '0'
  function automatic logic signed [8:0] digit(input logic [CHAR_W-1:0] b);
    return $signed({1'b0, b}) - 9'sd48;
  endfunction

  // tens*10 + units from two bytes
  function automatic logic signed [TVAL_W-1:0] two_digits(input logic [CHAR_W-1:0] t,
                                                          input logic [CHAR_W-1:0] u);
    logic signed [TVAL_W-1:0] dt;
    logic signed [TVAL_W-1:0] du;
    dt = TVAL_W'(digit(t));
    du = TVAL_W'(digit(u));
    return dt * 13'sd10 + du;
  endfunction

  // Write flag: clear it at the wrap points of the current reading
  function automatic logic wrap_guard(input logic [5:0] now,
                                      input logic signed [TVAL_W-1:0] val,
                                      input logic [5:0] top);
    logic skip;
    skip = ((now == 6'd0) && (val < 13'sd0)) ||
           ((now == top) && (val > $signed(TVAL_W'(now))));
    return !skip;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/slp_line_buf.sv
// Line store of the parser: byte registers preset to '0' and the write position.
// Depends on slp_pkg.
`default_nettype none

module slp_line_buf #(
  parameter int LINE_LEN = slp_pkg::LINE_LEN_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire slp_pkg::line_op_t                     op,
  output logic [LINE_LEN-1:0][slp_pkg::CHAR_W-1:0]   line
);
  import slp_pkg::*;

  localparam int POS_W = $clog2(LINE_LEN + 1);

  logic [POS_W-1:0] write_pos;
  logic             full;
  logic             keep_char;

  assign full      = (write_pos >= POS_W'(LINE_LEN));
  assign keep_char = (op.char_in != CH_CR) && (op.char_in != CH_LF) &&
                     (op.char_in != CH_NUL);

  // Advance the write position, wrap it on a full line
  always_ff @(posedge clk) begin
    if (rst || op.clear) begin
      write_pos <= '0;
    end else if (op.append) begin
      if (full) begin
        write_pos <= '0;
      end else if (keep_char) begin
        write_pos <= write_pos + POS_W'(1);
      end
    end
  end

  // Store the byte at the write position, preset all bytes on clear
  always_ff @(posedge clk) begin
    for (int i = 0; i < LINE_LEN; i++) begin
      if (rst || op.clear) begin
        line[i] <= FILL_CHAR;
      end else if (op.append && !full && keep_char && (write_pos == POS_W'(i))) begin
        line[i] <= op.char_in;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/slp_cmd_exec.sv
// Command decoder and settings registers: language, alarm levels, clock writes.
// Depends on slp_pkg; reads the bytes held by slp_line_buf.
`default_nettype none

module slp_cmd_exec #(
  parameter int LINE_LEN   = slp_pkg::LINE_LEN_DEF,
  parameter int LANG_COUNT = slp_pkg::LANG_COUNT_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 exec,
  input  wire logic [LINE_LEN-1:0][slp_pkg::CHAR_W-1:0] line,
  input  wire slp_pkg::item_t                       item,
  input  wire logic [slp_pkg::LEVEL_W-1:0]          level_min,
  input  wire logic [slp_pkg::LEVEL_W-1:0]          level_max,
  output slp_pkg::result_t                          result
);
  import slp_pkg::*;

  logic [LANG_W-1:0]  language_reg;
  logic [LEVEL_W-1:0] stored_low;
  logic [LEVEL_W-1:0] stored_high;
  logic [LANG_W-1:0]  language_next;
  logic [LEVEL_W-1:0] stored_low_next;
  logic [LEVEL_W-1:0] stored_high_next;

  logic                      lang_hit;
  logic [LANG_W-1:0]         lang_idx;
  logic signed [ALARM_W-1:0] alarm_val;
  logic [LEVEL_W-1:0]        alarm_clamped;
  logic                      is_lang;
  logic                      is_alarm;
  logic                      is_time;
  logic                      framed;
  logic signed [TVAL_W-1:0]  hours_val;
  logic signed [TVAL_W-1:0]  minutes_val;
  logic signed [TVAL_W-1:0]  seconds_val;

  // Search the language codes, first match wins
  always_comb begin
    lang_hit = 1'b0;
    lang_idx = '0;
    for (int i = 0; i < LANG_CODE_N; i++) begin
      if (!lang_hit && (line[2] == LANG_CODES[i][15:8]) && (line[3] == LANG_CODES[i][7:0]))
      begin
        lang_hit = 1'b1;
        lang_idx = LANG_W'(i % LANG_COUNT);
      end
    end
  end

  // Four-digit alarm level and its clamp
  always_comb begin
    alarm_val = ALARM_W'(digit(line[6])) * 19'sd1000 +
                ALARM_W'(digit(line[7])) * 19'sd100 +
                ALARM_W'(digit(line[8])) * 19'sd10 +
                ALARM_W'(digit(line[9]));
    if (alarm_val > $signed(ALARM_W'(level_max))) begin
      alarm_clamped = level_max;
    end else if (alarm_val < $signed(ALARM_W'(level_min))) begin
      alarm_clamped = level_min;
    end else begin
      alarm_clamped = alarm_val[LEVEL_W-1:0];
    end
  end

  assign is_lang  = (line[1] == CH_L);
  assign is_alarm = (line[0] == CH_SLASH) && (line[1] == CH_A) &&
                    (line[2] == CH_L) && (line[3] == CH_M);
  assign is_time  = (line[1] == CH_H) && (line[2] == CH_COLON) && (line[5] == CH_M) &&
                    (line[6] == CH_COLON) && (line[9] == CH_S) && (line[10] == CH_COLON);
  assign framed   = (line[5] == CH_LBRACK) && (line[10] == CH_RBRACK);

  assign hours_val   = two_digits(line[3], line[4]);
  assign minutes_val = two_digits(line[7], line[8]);
  assign seconds_val = two_digits(line[11], line[12]);

  // Decode the line into the next settings and the result
  always_comb begin
    language_next    = language_reg;
    stored_low_next  = stored_low;
    stored_high_next = stored_high;
    result           = '0;
    result.command   = CMD_NONE;
    priority if (is_lang) begin
      if (lang_hit) begin
        language_next  = lang_idx;
        result.command = CMD_LANGUAGE;
      end
    end else if (is_alarm) begin
      if (framed && (line[4] == CH_L)) begin
        if (alarm_clamped < stored_high) begin
          stored_low_next = alarm_clamped;
        end
        result.command = CMD_ALARM_LOW;
      end else if (framed && (line[4] == CH_H)) begin
        if (alarm_clamped > stored_low) begin
          stored_high_next = alarm_clamped;
        end
        result.command = CMD_ALARM_HIGH;
      end
    end else if (is_time) begin
      result.command       = CMD_TIME;
      result.hours_write   = wrap_guard({1'b0, item.now_hours}, hours_val, HOUR_TOP);
      result.hours_value   = hours_val;
      result.minutes_write = wrap_guard(item.now_minutes, minutes_val, MINSEC_TOP);
      result.minutes_value = minutes_val;
      result.seconds_write = wrap_guard(item.now_seconds, seconds_val, MINSEC_TOP);
      result.seconds_value = seconds_val;
    end else begin
      // unknown line: report no command, keep the settings
      result.command = CMD_NONE;
    end
    result.language_sel = language_next;
    result.level_low    = stored_low_next;
    result.level_high   = stored_high_next;
  end

  // Commit the settings when an execute beat leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      language_reg <= '0;
      stored_low   <= STORED_LOW_RST;
      stored_high  <= STORED_HIGH_RST;
    end else if (exec) begin
      language_reg <= language_next;
      stored_low   <= stored_low_next;
      stored_high  <= stored_high_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/serial_command_line_parser.sv
// Top level of the serial command line parser: input register, line buffer,
// command decoder and result register. Depends on slp_pkg, slp_line_buf, slp_cmd_exec.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid / s_tready  s_tuser kind, s_tdata char and clock reading
//   m_*      out  m_tvalid / m_tready  m_tuser command, m_tdata levels and time fields
//   cfg_*    in   cfg_we               cfg_index selects level_min / level_max
//
// One beat per cycle while no execute beat stalls: a beat is held in the input register,
// then the line buffer and decoder act on it; an execute beat loads the result register.
// An execute beat raises m_tvalid as it loads the result register; other kinds give none.
// Reset presets the line to '0', the levels to 0 / 1000 and the language to 0.
// A held result stalls an execute beat in the input register and with it s_tready;
// appends and clears in the input register never wait.
`default_nettype none

module serial_command_line_parser #(
  parameter int LINE_LEN   = slp_pkg::LINE_LEN_DEF,
  parameter int LANG_COUNT = slp_pkg::LANG_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // bits from 0: char_in[7:0], now_hours[12:8], now_minutes[18:13],
  // now_seconds[24:19], zero pad
  input  wire logic [31:0]                  s_tdata,
  // bits from 0: kind[1:0]
  input  wire logic [1:0]                   s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // bits from 0: language_sel[2:0], level_low[12:3], level_high[22:13],
  // hours_write[23], hours_value[36:24], minutes_write[37], minutes_value[50:38],
  // seconds_write[51], seconds_value[64:52], zero pad
  output logic [71:0]                       m_tdata,
  // bits from 0: command[2:0]
  output logic [2:0]                        m_tuser,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [slp_pkg::LEVEL_W-1:0]  cfg_wdata
);
  import slp_pkg::*;

  logic               in_valid;
  item_t              in_item;
  logic               in_exec;
  logic               advance;
  logic               out_free;
  line_op_t           line_op;
  logic [LINE_LEN-1:0][CHAR_W-1:0] line;
  result_t            result;
  result_t            out_res;
  logic [LEVEL_W-1:0] level_min;
  logic [LEVEL_W-1:0] level_max;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_min <= LEVEL_MIN_RST;
      level_max <= LEVEL_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEVEL_MIN: level_min <= cfg_wdata;
        CFG_LEVEL_MAX: level_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: an execute beat waits for a free result slot
  assign in_exec  = (in_item.kind == KIND_EXEC);
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_exec || out_free);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind        <= s_tuser;
      in_item.char_in     <= s_tdata[7:0];
      in_item.now_hours   <= s_tdata[12:8];
      in_item.now_minutes <= s_tdata[18:13];
      in_item.now_seconds <= s_tdata[24:19];
    end
  end

  // Line buffer update request
  assign line_op.append  = advance && (in_item.kind == KIND_APPEND);
  assign line_op.clear   = advance && (in_item.kind == KIND_CLEAR);
  assign line_op.char_in = in_item.char_in;

  slp_line_buf #(
    .LINE_LEN (LINE_LEN)
  ) u_line_buf (
    .clk  (clk),
    .rst  (rst),
    .op   (line_op),
    .line (line)
  );

  slp_cmd_exec #(
    .LINE_LEN   (LINE_LEN),
    .LANG_COUNT (LANG_COUNT)
  ) u_cmd_exec (
    .clk        (clk),
    .rst        (rst),
    .exec       (advance && in_exec),
    .line       (line),
    .item       (in_item),
    .level_min  (level_min),
    .level_max  (level_max),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_exec) begin
      out_res <= result;
    end
  end

  // Pack the result beat
  assign m_tuser = out_res.command;
  assign m_tdata = {7'd0,
                    out_res.seconds_value, out_res.seconds_write,
                    out_res.minutes_value, out_res.minutes_write,
                    out_res.hours_value, out_res.hours_write,
                    out_res.level_high, out_res.level_low,
                    out_res.language_sel};

  // Stored low level always stays below the high level
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.level_low < out_res.level_high))
    else $error("alarm levels out of order");

  // Language index stays within the configured list
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.language_sel < LANG_W'(LANG_COUNT)))
    else $error("language index out of range");

  // Time fields are zero for every command other than a clock set
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.command != CMD_TIME)) |->
      (!out_res.hours_write && !out_res.minutes_write && !out_res.seconds_write &&
       (out_res.hours_value == '0) && (out_res.minutes_value == '0) &&
       (out_res.seconds_value == '0)))
    else $error("time fields set without a clock command");

endmodule

`default_nettype wire
